// ===== rtl/dvfc_pkg.sv =====
package dvfc_pkg;

    localparam int SAMPLE_W = 32;
    localparam int COUNT_W  = 32;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic        [COUNT_W-1:0]  count_t;

    localparam count_t COUNT_MAX = '1;
    localparam count_t COUNT_ONE = count_t'(1);

endpackage

// ===== rtl/distinct_value_frequency_counter.sv =====
// Channel   Direction  Handshake                    Payload
// sample    in         sample_valid / sample_stall  sample, end_of_set
// entry     out        entry_valid / entry_stall    entry_value, entry_count,
//                                                   table_overflow, final_entry
//
// Search: a sample is compared with the entries in use from entry zero on; a new
//   one is appended, or flags overflow if the table is full. The search reads one
//   value/count pair a cycle; emission loads each entry once the output is free.
// Reset clears the fill count, the overflow flag and control; the fill count
//   marks which table entries hold data, so the memories are not cleared.
// Stalls: sample_stall is high during a search or an emission only.
module distinct_value_frequency_counter #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    sample_valid,
    output logic                    sample_stall,
    input  dvfc_pkg::sample_t       sample,
    input  logic                    end_of_set,

    output logic                    entry_valid,
    input  logic                    entry_stall,
    output dvfc_pkg::sample_t       entry_value,
    output dvfc_pkg::count_t        entry_count,
    output logic                    table_overflow,
    output logic                    final_entry
);

    // Index width for the memories; fill width holds the depth itself.
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        EMIT_READ,
        EMIT_LOAD
    } state_t;

    state_t                 state_reg, state_next;
    dvfc_pkg::sample_t      sample_reg, sample_next;
    logic                   last_reg, last_next;
    logic [CNT_W-1:0]       used_reg, used_next;
    logic                   overflow_reg, overflow_next;
    logic [CNT_W-1:0]       rd_addr_reg, rd_addr_next;
    logic                   cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]       cmp_addr_reg, cmp_addr_next;
    logic [IDX_W-1:0]       emit_addr_reg, emit_addr_next;

    logic                   entry_valid_reg, entry_valid_next;
    dvfc_pkg::sample_t      entry_value_reg, entry_value_next;
    dvfc_pkg::count_t       entry_count_reg, entry_count_next;
    logic                   table_overflow_reg, table_overflow_next;
    logic                   final_entry_reg, final_entry_next;

    // Memory ports
    logic                   rd_en;
    logic [IDX_W-1:0]       rd_addr;
    logic                   value_we;
    logic                   count_we;
    logic [IDX_W-1:0]       wr_addr;
    dvfc_pkg::sample_t      wr_value;
    dvfc_pkg::count_t       wr_count;
    dvfc_pkg::sample_t      value_q;
    dvfc_pkg::count_t       count_q;

    dvfc_pkg::sample_t      value_mem [TABLE_DEPTH];
    dvfc_pkg::count_t       count_mem [TABLE_DEPTH];

    logic [CNT_W-1:0]       last_idx;
    logic                   hit;
    logic                   scan_end;
    logic                   emit_final;
    logic                   out_free;
    logic                   emit_load;

    assign last_idx   = used_reg - CNT_W'(1);
    assign hit        = cmp_valid_reg && (value_q == sample_reg);
    assign scan_end   = cmp_valid_reg && (CNT_W'(cmp_addr_reg) == last_idx);
    assign emit_final = (CNT_W'(emit_addr_reg) == last_idx);
    assign out_free   = !entry_valid_reg || !entry_stall;
    assign emit_load  = (state_reg == EMIT_LOAD) && out_free;

    // Value table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (value_we)
        begin
            value_mem[wr_addr] <= wr_value;
        end
        if (rd_en)
        begin
            value_q <= value_mem[rd_addr];
        end
    end

    // Count table, addressed in step with the value table.
    always_ff @(posedge clk)
    begin
        if (count_we)
        begin
            count_mem[wr_addr] <= wr_count;
        end
        if (rd_en)
        begin
            count_q <= count_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next          = state_reg;
        sample_next         = sample_reg;
        last_next           = last_reg;
        used_next           = used_reg;
        overflow_next       = overflow_reg;
        rd_addr_next        = rd_addr_reg;
        cmp_valid_next      = cmp_valid_reg;
        cmp_addr_next       = cmp_addr_reg;
        emit_addr_next      = emit_addr_reg;

        entry_valid_next    = entry_valid_reg;
        entry_value_next    = entry_value_reg;
        entry_count_next    = entry_count_reg;
        table_overflow_next = table_overflow_reg;
        final_entry_next    = final_entry_reg;

        rd_en    = 1'b0;
        rd_addr  = '0;
        value_we = 1'b0;
        count_we = 1'b0;
        wr_addr  = used_reg[IDX_W-1:0];
        wr_value = sample_reg;
        wr_count = dvfc_pkg::COUNT_ONE;

        // Drop the output once its transfer completes.
        if (entry_valid_reg && !entry_stall)
        begin
            entry_valid_next = 1'b0;
        end

        case (state_reg)
            IDLE:
            begin
                if (sample_valid)
                begin
                    sample_next    = sample;
                    last_next      = end_of_set;
                    emit_addr_next = '0;
                    if (used_reg == '0)
                    begin
                        // Empty table: append straight away.
                        value_we   = 1'b1;
                        count_we   = 1'b1;
                        wr_addr    = '0;
                        wr_value   = sample;
                        used_next  = CNT_W'(1);
                        state_next = end_of_set ? EMIT_READ : IDLE;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = '0;
                        cmp_valid_next = 1'b1;
                        cmp_addr_next  = '0;
                        rd_addr_next   = CNT_W'(1);
                        state_next     = SCAN;
                    end
                end
            end

            SCAN:
            begin
                if (hit)
                begin
                    count_we = 1'b1;
                    wr_addr  = cmp_addr_reg;
                    wr_count = (count_q == dvfc_pkg::COUNT_MAX) ? count_q
                                                                : count_q + dvfc_pkg::COUNT_ONE;
                    cmp_valid_next = 1'b0;
                    state_next     = last_reg ? EMIT_READ : IDLE;
                end
                else if (scan_end)
                begin
                    if (used_reg < CNT_W'(TABLE_DEPTH))
                    begin
                        value_we  = 1'b1;
                        count_we  = 1'b1;
                        used_next = used_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    cmp_valid_next = 1'b0;
                    state_next     = last_reg ? EMIT_READ : IDLE;
                end
                else
                begin
                    // Advance the search: issue the next read, compare the last.
                    if (rd_addr_reg < used_reg)
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = rd_addr_reg[IDX_W-1:0];
                        cmp_valid_next = 1'b1;
                        cmp_addr_next  = rd_addr_reg[IDX_W-1:0];
                        rd_addr_next   = rd_addr_reg + CNT_W'(1);
                    end
                    else
                    begin
                        cmp_valid_next = 1'b0;
                    end
                end
            end

            EMIT_READ:
            begin
                rd_en      = 1'b1;
                rd_addr    = emit_addr_reg;
                state_next = EMIT_LOAD;
            end

            EMIT_LOAD:
            begin
                if (out_free)
                begin
                    entry_valid_next    = 1'b1;
                    entry_value_next    = value_q;
                    entry_count_next    = count_q;
                    table_overflow_next = overflow_reg;
                    final_entry_next    = emit_final;
                    if (emit_final)
                    begin
                        // Clear the table; the last entry waits in the output register.
                        used_next     = '0;
                        overflow_next = 1'b0;
                        state_next    = IDLE;
                    end
                    else
                    begin
                        emit_addr_next = emit_addr_reg + IDX_W'(1);
                        state_next     = EMIT_READ;
                    end
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= IDLE;
            used_reg        <= '0;
            overflow_reg    <= 1'b0;
            cmp_valid_reg   <= 1'b0;
            entry_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            used_reg        <= used_next;
            overflow_reg    <= overflow_next;
            cmp_valid_reg   <= cmp_valid_next;
            entry_valid_reg <= entry_valid_next;
        end
    end

    // Payload and address registers: no reset needed.
    always_ff @(posedge clk)
    begin
        sample_reg         <= sample_next;
        last_reg           <= last_next;
        rd_addr_reg        <= rd_addr_next;
        cmp_addr_reg       <= cmp_addr_next;
        emit_addr_reg      <= emit_addr_next;
        entry_value_reg    <= entry_value_next;
        entry_count_reg    <= entry_count_next;
        table_overflow_reg <= table_overflow_next;
        final_entry_reg    <= final_entry_next;
    end

    assign sample_stall   = (state_reg != IDLE);
    assign entry_valid    = entry_valid_reg;
    assign entry_value    = entry_value_reg;
    assign entry_count    = entry_count_reg;
    assign table_overflow = table_overflow_reg;
    assign final_entry    = final_entry_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_scan_compare: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN) |-> cmp_valid_reg)
        else $error("search running without a pending compare");

    a_clear_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && emit_final) |=> (used_reg == '0) && !overflow_reg)
        else $error("table not cleared after final entry");

    a_output_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(entry_valid_reg) |-> ($past(state_reg) == EMIT_LOAD))
        else $error("result raised outside emission");
`endif

endmodule

// ===== verif/tb_distinct_value_frequency_counter.sv =====
`timescale 1ns / 100ps

typedef struct {
    dvfc_pkg::sample_t value;
    dvfc_pkg::count_t  count;
    logic              spilled;
    logic              closing;
} histogram_entry_t;

// Running histogram of the current set plus the entries still owed by the block.
class histogram_book;
    dvfc_pkg::sample_t bin_value[$];
    dvfc_pkg::count_t  bin_count[$];
    bit                spilled;
    histogram_entry_t  due[$];
    int                depth;
    int unsigned       errors;
    int unsigned       sets_closed;
    int unsigned       entries_matched;
    int unsigned       spill_sets;
    int unsigned       widest_set;

    function new(int table_depth);
        depth = table_depth;
    endfunction

    function int unsigned waiting();
        return due.size();
    endfunction

    // Count one accepted sample; on the closing sample, queue the whole table.
    function void note_sample(dvfc_pkg::sample_t v, logic closing);
        int               k;
        bit               hit;
        histogram_entry_t e;
        hit = 1'b0;
        for (k = 0; k < bin_value.size(); k++)
        begin
            if (!hit && bin_value[k] == v)
            begin
                hit = 1'b1;
                if (bin_count[k] != dvfc_pkg::COUNT_MAX)
                    bin_count[k] = bin_count[k] + dvfc_pkg::COUNT_ONE;
            end
        end
        if (!hit)
        begin
            if (bin_value.size() < depth)
            begin
                bin_value.push_back(v);
                bin_count.push_back(dvfc_pkg::COUNT_ONE);
            end
            else
                spilled = 1'b1;
        end
        if (closing)
        begin
            for (k = 0; k < bin_value.size(); k++)
            begin
                e.value   = bin_value[k];
                e.count   = bin_count[k];
                e.spilled = spilled;
                e.closing = (k == bin_value.size() - 1);
                due.push_back(e);
            end
            sets_closed++;
            if (spilled)
                spill_sets++;
            if (bin_value.size() > widest_set)
                widest_set = bin_value.size();
            bin_value.delete();
            bin_count.delete();
            spilled = 1'b0;
        end
    endfunction

    task report(string what);
        errors++;
        if (errors <= 40)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_entry(dvfc_pkg::sample_t v, dvfc_pkg::count_t c, logic ovf, logic fin);
        histogram_entry_t e;
        if (due.size() == 0)
        begin
            report($sformatf("entry value=%0d count=%0d with nothing outstanding", v, c));
            return;
        end
        e = due.pop_front();
        if (v !== e.value)
            report($sformatf("entry_value %0d, want %0d", v, e.value));
        if (c !== e.count)
            report($sformatf("entry_count %0d for value %0d, want %0d", c, e.value, e.count));
        if (ovf !== e.spilled)
            report($sformatf("table_overflow %b for value %0d, want %b", ovf, e.value,
                             e.spilled));
        if (fin !== e.closing)
            report($sformatf("final_entry %b for value %0d, want %b", fin, e.value,
                             e.closing));
        entries_matched++;
    endtask
endclass

module tb_distinct_value_frequency_counter;

    localparam int TABLE_DEPTH     = 64;
    // Random-part budget; the directed sets bring the total to about 230.
    localparam int RANDOM_ITEMS    = 212;
    // Long receiver hold-off, long enough to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 300;
    // Cycles without any transfer before the run is declared hung. The worst
    // honest quiet spell is the hold-off plus a full search plus a long gap.
    localparam int QUIET_LIMIT     = 4000;
    // Settle time after the last result, sized to cover a full emission.
    localparam int TAIL_CYCLES     = 2 * TABLE_DEPTH + 20;

    logic              clk;
    logic              rst_n;
    logic              sample_valid;
    logic              sample_stall;
    dvfc_pkg::sample_t sample;
    logic              end_of_set;
    logic              entry_valid;
    logic              entry_stall;
    dvfc_pkg::sample_t entry_value;
    dvfc_pkg::count_t  entry_count;
    logic              table_overflow;
    logic              final_entry;

    histogram_book book;
    bit            hold_off_pending;
    int unsigned   hold_offs;

    distinct_value_frequency_counter #(
        .TABLE_DEPTH    (TABLE_DEPTH)
    ) uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .end_of_set     (end_of_set),
        .entry_valid    (entry_valid),
        .entry_stall    (entry_stall),
        .entry_value    (entry_value),
        .entry_count    (entry_count),
        .table_overflow (table_overflow),
        .final_entry    (final_entry)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length for either side: none in eager stretches, otherwise mostly
    // nothing or a short pause, now and then a long one.
    function automatic int unsigned idle_span(bit eager);
        int unsigned roll;
        if (eager)
            return 0;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one sample and hold it until the block takes it. Called at a rising
    // edge and returns at the edge of the transfer, with valid still high so
    // that back-to-back samples never drop valid within a time step.
    task automatic offer_sample(input dvfc_pkg::sample_t v, input logic closing,
                                input bit eager);
        int unsigned gap;
        gap = idle_span(eager);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= v;
        end_of_set   <= closing;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        book.note_sample(v, closing);
    endtask

    // Drop valid and hold off the sender until every owed entry has come out.
    task automatic drain_entries();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (book.waiting() != 0)
            @(posedge clk);
    endtask

    // Directed sets: a lone extreme, the extremes with repeats (the closing
    // sample a repeat), alternating bit patterns closing on a new value, and a
    // set whose closing sample repeats its opener.
    task automatic run_directed();
        offer_sample(dvfc_pkg::sample_t'(32'h8000_0000), 1'b0 | 1'b1, 1'b1);

        // Let the receiver stall for a long stretch while this set empties;
        // the next set is offered regardless, so the block backs up.
        hold_off_pending = 1'b1;
        offer_sample(dvfc_pkg::sample_t'(32'h7FFF_FFFF), 1'b0, 1'b1);
        offer_sample(dvfc_pkg::sample_t'(32'h0000_0000), 1'b0, 1'b1);
        offer_sample(dvfc_pkg::sample_t'(32'hFFFF_FFFF), 1'b0, 1'b1);
        offer_sample(dvfc_pkg::sample_t'(32'h7FFF_FFFF), 1'b0, 1'b1);
        offer_sample(dvfc_pkg::sample_t'(32'h0000_0000), 1'b0, 1'b1);
        offer_sample(dvfc_pkg::sample_t'(32'h7FFF_FFFF), 1'b0, 1'b1);
        offer_sample(dvfc_pkg::sample_t'(32'h0000_0001), 1'b0, 1'b1);
        offer_sample(dvfc_pkg::sample_t'(32'hFFFF_FFFF), 1'b1, 1'b1);

        offer_sample(dvfc_pkg::sample_t'(32'h5555_5555), 1'b0, 1'b0);
        offer_sample(dvfc_pkg::sample_t'(32'hAAAA_AAAA), 1'b0, 1'b0);
        offer_sample(dvfc_pkg::sample_t'(32'h5555_5555), 1'b0, 1'b0);
        offer_sample(dvfc_pkg::sample_t'(32'hAAAA_AAAA), 1'b0, 1'b0);
        offer_sample(dvfc_pkg::sample_t'(32'h0000_FFFF), 1'b1, 1'b0);

        offer_sample(dvfc_pkg::sample_t'(32'hFFFF_0000), 1'b0, 1'b0);
        offer_sample(dvfc_pkg::sample_t'(32'h1234_5678), 1'b0, 1'b0);
        offer_sample(dvfc_pkg::sample_t'(32'h8000_0000), 1'b0, 1'b0);
        offer_sample(dvfc_pkg::sample_t'(32'hFFFF_0000), 1'b1, 1'b0);
    endtask

    // Random sets. One set fills the table exactly, one overruns it; the rest
    // are short sets drawn mostly from a small pool so that repeats are common.
    task automatic run_random_sets();
        int unsigned sent;
        int unsigned set_no;
        int unsigned len;
        int unsigned k;
        bit          eager;
        bit [31:0]   base;
        bit [31:0]   stride;
        bit [31:0]   pick;
        bit [31:0]   pool[6];
        sent   = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            eager  = (set_no % 4 == 2);
            base   = $urandom;
            // An odd stride keeps base + k * stride distinct for every k.
            stride = $urandom | 32'd1;
            if (set_no == 1)
            begin
                // Fill to the brim: the closing sample takes the last free entry.
                for (k = 0; k < TABLE_DEPTH; k++)
                    offer_sample(base + k * stride, k == TABLE_DEPTH - 1, eager);
                sent += TABLE_DEPTH;
            end
            else if (set_no == 4)
            begin
                // Overrun: fill, then mix dropped newcomers with repeats of
                // held values; the first sample past the fill is always new.
                len = $urandom_range(10, 4);
                for (k = 0; k < TABLE_DEPTH + len; k++)
                begin
                    if (k < TABLE_DEPTH || k == TABLE_DEPTH || $urandom_range(1) == 1)
                        pick = base + k * stride;
                    else
                        pick = base + $urandom_range(TABLE_DEPTH - 1) * stride;
                    offer_sample(pick, k == TABLE_DEPTH + len - 1, eager);
                end
                sent += TABLE_DEPTH + len;
            end
            else
            begin
                for (k = 0; k < 6; k++)
                begin
                    case ($urandom_range(7))
                        0:       pool[k] = 32'h8000_0000;
                        1:       pool[k] = 32'h7FFF_FFFF;
                        2:       pool[k] = 32'hFFFF_FFFF;
                        3:       pool[k] = 32'h0000_0000;
                        default: pool[k] = $urandom;
                    endcase
                end
                len = $urandom_range(12, 1);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(9) < 7)
                        pick = pool[$urandom_range(5)];
                    else
                        pick = $urandom;
                    offer_sample(pick, k == len - 1, eager);
                end
                sent += len;
            end
            // Now and then hold the sender back until the block has emptied.
            if (set_no % 5 == 3)
                drain_entries();
            set_no++;
        end
    endtask

    // Result side: check each transfer, then pick the next stall value. Stall
    // runs are random, with eager stretches of no stall at all, and one long
    // hold-off when the sender asks for it.
    initial
    begin : entry_sink
        int unsigned stall_left;
        int unsigned mode_left;
        bit          eager;
        stall_left  = 0;
        mode_left   = 0;
        eager       = 1'b0;
        entry_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (entry_valid && !entry_stall)
                book.check_entry(entry_value, entry_count, table_overflow, final_entry);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                stall_left       = HOLD_OFF_CYCLES;
                hold_offs++;
            end
            else if (stall_left == 0)
            begin
                if (mode_left == 0)
                begin
                    eager     = !eager;
                    mode_left = $urandom_range(300, 40);
                end
                else
                    mode_left--;
                stall_left = idle_span(eager);
            end
            if (stall_left != 0)
            begin
                entry_stall <= 1'b1;
                stall_left--;
            end
            else
                entry_stall <= 1'b0;
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    initial
    begin : watchdog
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((sample_valid && !sample_stall) || (entry_valid && !entry_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] timeout: no transfer for %0d cycles, %0d entries outstanding",
                 $time, QUIET_LIMIT, book.waiting());
        $display("distinct_value_frequency_counter verification failed");
        $finish;
    end

    initial
    begin : stimulus
        book             = new(TABLE_DEPTH);
        hold_off_pending = 1'b0;
        hold_offs        = 0;
        rst_n            <= 1'b0;
        sample_valid     <= 1'b0;
        sample           <= '0;
        end_of_set       <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        drain_entries();
        run_random_sets();
        drain_entries();
        // Give any stray result time to show up before closing the books.
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d sets, %0d entries checked, widest emission %0d entries",
                 book.sets_closed, book.entries_matched, book.widest_set);
        $display("%0d set(s) overran the table; receiver held off %0d time(s) for %0d cycles",
                 book.spill_sets, hold_offs, HOLD_OFF_CYCLES);
        if (book.errors == 0)
            $display("distinct_value_frequency_counter verification clean");
        else
            $display("distinct_value_frequency_counter verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/dvfc_pkg.sv
rtl/distinct_value_frequency_counter.sv
verif/tb_distinct_value_frequency_counter.sv
